FILE: sv/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types, constants and functions of the Clarke/Park block
// Fixed-point widths, the quarter-wave sine table and the saturation helper.
// ----------------------------------------------------------------------------
package ccp_pkg;

	localparam int ADC_BITS      = 12;
	localparam int CUR_BITS      = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int SINE_DEPTH    = 256;
	localparam int SINE_IDX_W    = $clog2(SINE_DEPTH);
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_SHIFT    = 8;
	localparam int Q15_SHIFT     = 15;
	localparam int INV_SQRT3_Q15 = 18919;
	localparam int ROUND_Q15     = 16384;
	localparam int OUT_BITS      = 16;
	localparam int SAT_IN_W      = 48;
	localparam int SINE_VAL_W    = 15;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Taylor term divisors (2k)*(2k+1) for k = 1..8
	localparam longint unsigned TAYLOR_DIV [1:8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Scaled phase product: (ADC_BITS+1)-bit difference times (GAIN_BITS+1)-bit gain
	localparam int PROD_W = ADC_BITS + 1 + GAIN_BITS + 1;

	typedef logic signed [CUR_BITS-1:0] cur_t;
	typedef logic signed [OUT_BITS-1:0] out_t;
	typedef logic [SINE_VAL_W-1:0]      sine_val_t;
	typedef sine_val_t                  sine_tab_t [0:SINE_DEPTH];

	typedef enum logic [1:0] {
		CFG_OFFSET_A,
		CFG_OFFSET_B,
		CFG_CURRENT_GAIN
	} cfg_index_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic val_clip;
		out_t val;
	} sat_t;

	typedef struct packed {
		logic clipped;
		out_t i_quadrature;
		out_t i_direct;
		out_t i_beta;
		out_t i_alpha;
	} result_t;

	localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'((1 << (OUT_BITS - 1)) - 1);
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

	// Clamp to signed OUT_BITS and flag the clip
	function automatic sat_t sat_out(input logic signed [SAT_IN_W-1:0] v);
		sat_t r;
		r.val_clip = 1'b0;
		r.val      = v[OUT_BITS-1:0];
		if (v > SAT_HI) begin
			r.val_clip = 1'b1;
			r.val      = SAT_HI[OUT_BITS-1:0];
		end else if (v < SAT_LO) begin
			r.val_clip = 1'b1;
			r.val      = SAT_LO[OUT_BITS-1:0];
		end
		return r;
	endfunction

	// Quarter-wave sine in Q1.15, Taylor series in Q30, evaluated at elaboration
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t       tab;
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x    = (longint'(i) * HALF_PI_Q30) >> SINE_IDX_W;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				term = (term * x) >> 30;
				term = ((term * x) >> 30) / TAYLOR_DIV[k];
				if (k[0])
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			tab[i] = SINE_VAL_W'(((longint'(sum) * 32767) + (longint'(1) << 29)) >> 30);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/phase_current_clarke_park.sv
// ----------------------------------------------------------------------------
// phase_current_clarke_park: phase currents to alpha/beta and d/q
// Scales two ADC phase samples, applies Clarke and Park transforms.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request per ADC conversion, carrying both phase
//   samples and the electrical angle. Output stream m_*: one result per
//   request, in order: alpha, beta, d, q in tdata, the saturation flag in
//   tuser. Configuration channel cfg_*: writes offset_a (index 0), offset_b
//   (index 1) and current_gain (index 2); it is always ready. Write it only
//   while no request is in flight.
//   Path: a request accepted at one clock edge loads stage 1, then passes
//   stages 2 to 5 and the output register before it shows on m_tvalid.
//   Throughput: one request per cycle while the skid stage is empty; every
//   stage holds one multiply or one add/round/saturate, and the sine lookup
//   is a registered table read.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (offsets 2048, gain 256). No clearing pass; accepts at once after reset.
//   Stall: when the receiver holds m_tready low, the result waits in the
//   output register and one more lands in the skid stage; s_tready then
//   drops and the whole pipeline holds until the skid stage drains.
// ----------------------------------------------------------------------------
module phase_current_clarke_park (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // adc_a[11:0], adc_b[23:12], electrical_angle[39:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // i_alpha[15:0], i_beta[31:16], i_direct[47:32],
	                               // i_quadrature[63:48]
	output logic        m_tuser,   // clipped[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ccp_pkg::*;

	logic [ADC_BITS-1:0]   offset_a_q;
	logic [ADC_BITS-1:0]   offset_b_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [ADC_BITS-1:0]   adc_a;
	logic [ADC_BITS-1:0]   adc_b;
	logic [ANGLE_BITS-1:0] angle;
	logic                  en;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  v_s4;
	logic                  v_s5;
	cur_t                  a_s2;
	cur_t                  b_s2;
	logic                  clip_a_s2;
	logic                  clip_b_s2;
	out_t                  sin_s3;
	out_t                  cos_s3;
	result_t               res;
	result_t               res_out;

	// Unpack the request
	assign adc_a = s_tdata[ADC_BITS-1:0];
	assign adc_b = s_tdata[2*ADC_BITS-1:ADC_BITS];
	assign angle = s_tdata[2*ADC_BITS+ANGLE_BITS-1:2*ADC_BITS];

	// Configuration registers; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_a_q <= ADC_BITS'(2048);
			offset_b_q <= ADC_BITS'(2048);
			gain_q     <= GAIN_BITS'(256);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OFFSET_A:     offset_a_q <= cfg_data[ADC_BITS-1:0];
				CFG_OFFSET_B:     offset_b_q <= cfg_data[ADC_BITS-1:0];
				CFG_CURRENT_GAIN: gain_q     <= cfg_data[GAIN_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// Whole pipeline advances together while the skid stage is empty
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stages 1-2: offset, gain, floor and saturate per phase
	ccp_phase_scale u_scale_a (
		.clk     (clk),
		.en      (en),
		.adc     (adc_a),
		.offset  (offset_a_q),
		.gain    (gain_q),
		.cur_s2  (a_s2),
		.clip_s2 (clip_a_s2)
	);

	ccp_phase_scale u_scale_b (
		.clk     (clk),
		.en      (en),
		.adc     (adc_b),
		.offset  (offset_b_q),
		.gain    (gain_q),
		.cur_s2  (b_s2),
		.clip_s2 (clip_b_s2)
	);

	// Stages 1-3: quadrant split, table read, sign fold
	ccp_sincos u_sincos (
		.clk    (clk),
		.en     (en),
		.angle  (angle),
		.sin_s3 (sin_s3),
		.cos_s3 (cos_s3)
	);

	// Stages 3-5 and final round/saturate
	ccp_clarke_park u_rotate (
		.clk     (clk),
		.en      (en),
		.a_s2    (a_s2),
		.b_s2    (b_s2),
		.clip_s2 (clip_a_s2 | clip_b_s2),
		.sin_s3  (sin_s3),
		.cos_s3  (cos_s3),
		.res     (res)
	);

	ccp_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en & v_s5),
		.res_in   (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_out  (res_out),
		.room     (en)
	);

	assign m_tdata = {res_out.i_quadrature, res_out.i_direct, res_out.i_beta,
	                  res_out.i_alpha};
	assign m_tuser = res_out.clipped;

endmodule

FILE: sv/ccp_phase_scale.sv
// ----------------------------------------------------------------------------
// ccp_phase_scale: ADC sample to phase current
// Stage 1 removes the zero offset and multiplies by the gain; stage 2
// floors the product by the gain shift and saturates it.
// ----------------------------------------------------------------------------
module ccp_phase_scale (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ccp_pkg::ADC_BITS-1:0]  adc,
	input  logic [ccp_pkg::ADC_BITS-1:0]  offset,
	input  logic [ccp_pkg::GAIN_BITS-1:0] gain,
	output ccp_pkg::cur_t                 cur_s2,
	output logic                          clip_s2
);
	import ccp_pkg::*;

	logic signed [ADC_BITS:0]   diff;
	logic signed [GAIN_BITS:0]  gain_sx;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [PROD_W-1:0]   shifted;
	sat_t                       cur_sat;

	assign diff    = $signed({1'b0, adc}) - $signed({1'b0, offset});
	assign gain_sx = $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (en)
			prod_s1 <= PROD_W'(diff) * PROD_W'(gain_sx);
	end

	// arithmetic shift is a floor
	assign shifted = prod_s1 >>> GAIN_SHIFT;
	assign cur_sat = sat_out(SAT_IN_W'(shifted));

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s2  <= cur_sat.val;
			clip_s2 <= cur_sat.val_clip;
		end
	end

endmodule

FILE: sv/ccp_sincos.sv
// ----------------------------------------------------------------------------
// ccp_sincos: angle to Q1.15 sine and cosine
// Stage 1 splits quadrant and table index, stage 2 reads the quarter-wave
// table at both ends, stage 3 folds the quadrant into signs.
// ----------------------------------------------------------------------------
module ccp_sincos (
	input  logic                           clk,
	input  logic                           en,
	input  logic [ccp_pkg::ANGLE_BITS-1:0] angle,
	output ccp_pkg::out_t                  sin_s3,
	output ccp_pkg::out_t                  cos_s3
);
	import ccp_pkg::*;

	quad_t                 quad_s1;
	quad_t                 quad_s2;
	logic [SINE_IDX_W-1:0] idx_s1;
	logic [SINE_IDX_W:0]   comp_idx;
	sine_val_t             lo_s2;
	sine_val_t             hi_s2;
	out_t                  lo_pos;
	out_t                  hi_pos;

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad_t'(angle[ANGLE_BITS-1 -: 2]);
			idx_s1  <= angle[ANGLE_BITS-3 -: SINE_IDX_W];
		end
	end

	assign comp_idx = (SINE_IDX_W + 1)'(SINE_DEPTH) - {1'b0, idx_s1};

	// ROM read, registered
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2   <= SINE_TAB[{1'b0, idx_s1}];
			hi_s2   <= SINE_TAB[comp_idx];
			quad_s2 <= quad_s1;
		end
	end

	assign lo_pos = $signed({1'b0, lo_s2});
	assign hi_pos = $signed({1'b0, hi_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s2)
				QUAD_0: begin
					sin_s3 <= lo_pos;
					cos_s3 <= hi_pos;
				end
				QUAD_1: begin
					sin_s3 <= hi_pos;
					cos_s3 <= -lo_pos;
				end
				QUAD_2: begin
					sin_s3 <= -lo_pos;
					cos_s3 <= -hi_pos;
				end
				default: begin
					sin_s3 <= -hi_pos;
					cos_s3 <= lo_pos;
				end
			endcase
		end
	end

endmodule

FILE: sv/ccp_clarke_park.sv
// ----------------------------------------------------------------------------
// ccp_clarke_park: Clarke and Park rotation
// Stage 3 forms the beta products, stage 4 rounds and saturates beta,
// stage 5 forms the four rotation products; the final sum, round and
// saturate feed the output register.
// ----------------------------------------------------------------------------
module ccp_clarke_park (
	input  logic             clk,
	input  logic             en,
	input  ccp_pkg::cur_t    a_s2,
	input  ccp_pkg::cur_t    b_s2,
	input  logic             clip_s2,
	input  ccp_pkg::out_t    sin_s3,
	input  ccp_pkg::out_t    cos_s3,
	output ccp_pkg::result_t res
);
	import ccp_pkg::*;

	localparam int PA_W  = CUR_BITS + 17;
	localparam int PB_W  = CUR_BITS + 18;
	localparam int BS_W  = CUR_BITS + 19;
	localparam int ROT_W = 2 * OUT_BITS;
	localparam int RS_W  = ROT_W + 2;

	localparam logic signed [16:0] K1 = 17'(INV_SQRT3_Q15);
	localparam logic signed [17:0] K2 = 18'(2 * INV_SQRT3_Q15);
	localparam logic signed [BS_W-1:0] RND_B = BS_W'(ROUND_Q15);
	localparam logic signed [RS_W-1:0] RND_R = RS_W'(ROUND_Q15);

	sat_t                     alpha_sat;
	logic signed [PA_W-1:0]   pa_s3;
	logic signed [PB_W-1:0]   pb_s3;
	out_t                     alpha_s3;
	logic                     clip_s3;
	out_t                     sin_s4;
	out_t                     cos_s4;
	out_t                     alpha_s4;
	out_t                     beta_s4;
	logic                     clip_s4;
	logic signed [BS_W-1:0]   beta_sum;
	logic signed [BS_W-1:0]   beta_shr;
	sat_t                     beta_sat;
	logic signed [ROT_W-1:0]  ac_s5;
	logic signed [ROT_W-1:0]  bs_s5;
	logic signed [ROT_W-1:0]  bc_s5;
	logic signed [ROT_W-1:0]  as_s5;
	out_t                     alpha_s5;
	out_t                     beta_s5;
	logic                     clip_s5;
	logic signed [RS_W-1:0]   d_sum;
	logic signed [RS_W-1:0]   q_sum;
	logic signed [RS_W-1:0]   d_shr;
	logic signed [RS_W-1:0]   q_shr;
	sat_t                     d_sat;
	sat_t                     q_sat;

	assign alpha_sat = sat_out(SAT_IN_W'(a_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3    <= PA_W'(a_s2) * PA_W'(K1);
			pb_s3    <= PB_W'(b_s2) * PB_W'(K2);
			alpha_s3 <= alpha_sat.val;
			clip_s3  <= clip_s2 | alpha_sat.val_clip;
		end
	end

	assign beta_sum = BS_W'(pa_s3) + BS_W'(pb_s3) + RND_B;
	assign beta_shr = beta_sum >>> Q15_SHIFT;
	assign beta_sat = sat_out(SAT_IN_W'(beta_shr));

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s4 <= alpha_s3;
			beta_s4  <= beta_sat.val;
			clip_s4  <= clip_s3 | beta_sat.val_clip;
			sin_s4   <= sin_s3;
			cos_s4   <= cos_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s5    <= ROT_W'(alpha_s4) * ROT_W'(cos_s4);
			bs_s5    <= ROT_W'(beta_s4) * ROT_W'(sin_s4);
			bc_s5    <= ROT_W'(beta_s4) * ROT_W'(cos_s4);
			as_s5    <= ROT_W'(alpha_s4) * ROT_W'(sin_s4);
			alpha_s5 <= alpha_s4;
			beta_s5  <= beta_s4;
			clip_s5  <= clip_s4;
		end
	end

	assign d_sum = RS_W'(ac_s5) + RS_W'(bs_s5) + RND_R;
	assign q_sum = RS_W'(bc_s5) - RS_W'(as_s5) + RND_R;
	assign d_shr = d_sum >>> Q15_SHIFT;
	assign q_shr = q_sum >>> Q15_SHIFT;
	assign d_sat = sat_out(SAT_IN_W'(d_shr));
	assign q_sat = sat_out(SAT_IN_W'(q_shr));

	always_comb begin
		res.i_alpha      = alpha_s5;
		res.i_beta       = beta_s5;
		res.i_direct     = d_sat.val;
		res.i_quadrature = q_sat.val;
		res.clipped      = clip_s5 | d_sat.val_clip | q_sat.val_clip;
	end

endmodule

FILE: sv/ccp_out_buf.sv
// ----------------------------------------------------------------------------
// ccp_out_buf: output register with skid stage
// Holds the result for the receiver; a second entry catches the item that
// leaves the pipeline in the cycle the receiver stalls.
// ----------------------------------------------------------------------------
module ccp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ccp_pkg::result_t res_in,
	input  logic             m_tready,
	output logic             m_tvalid,
	output ccp_pkg::result_t res_out,
	output logic             room
);
	import ccp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res_in;
		end else if (push) begin
			skid_q <= res_in;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res_out  = out_q;
	assign room     = ~skid_valid_q;

	// skid entry is only ever behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	// a pushed item is never lost
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("pushed result did not reach the output");

	// push only while the skid entry is free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full skid stage");

	// a taken result with a waiting skid entry refills the output at once
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && m_tready && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output");

endmodule
